// File: sv/assert_macros.svh
// Assertion macros used by the console RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled during reset.
`define TCCW_ASSERT_NOW(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, disabled during reset.
`define TCCW_ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: sv/tccw_pkg.sv
// Package with constants, codes and types of the text console.
`default_nettype none
package tccw_pkg;
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF = 25;

	localparam int CELL_W = 16;
	localparam int CHAR_W = 8;
	localparam int COLOR_W = 8;
	localparam int ACTION_W = 2;
	localparam int POS_W = 7;
	localparam int ADDR_W = 11;
	localparam int ROW_OUT_W = 5;
	localparam int COL_OUT_W = 7;

	localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;
	localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h07;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE   = 2'd0,
		ACT_SET_ROW = 2'd1,
		ACT_SET_COL = 2'd2,
		ACT_READ    = 2'd3
	} action_t;

	typedef struct packed {
		logic busy;
		logic rd_en;
		logic wr_en;
		logic wr_zero;
	} sweep_ctl_t;
endpackage
`default_nettype wire

// File: sv/tccw_if.sv
// Valid/ready channel interfaces for console items and results.
`default_nettype none
interface tccw_in_if;
	import tccw_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [CHAR_W-1:0]   char_byte;
	logic [POS_W-1:0]    position_value;
	logic [ADDR_W-1:0]   cell_address;
	logic                end_of_write;

	modport source (output valid, action, char_byte, position_value, cell_address,
		end_of_write, input ready);
	modport sink (input valid, action, char_byte, position_value, cell_address,
		end_of_write, output ready);
endinterface

interface tccw_out_if;
	import tccw_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ROW_OUT_W-1:0] caret_row;
	logic [COL_OUT_W-1:0] caret_col;
	logic [ADDR_W-1:0]    cursor_position;
	logic [CHAR_W-1:0]    cell_char;
	logic [COLOR_W-1:0]   cell_color;

	modport source (output valid, caret_row, caret_col, cursor_position, cell_char,
		cell_color, input ready);
	modport sink (input valid, caret_row, caret_col, cursor_position, cell_char,
		cell_color, output ready);
endinterface
`default_nettype wire

// File: sv/tccw_screen_mem.sv
// Screen cell store: one write port, one registered read port.
`default_nettype none
module tccw_screen_mem #(
	parameter int DEPTH = tccw_pkg::ROWS_DEF * tccw_pkg::COLUMNS_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [AW-1:0]               wr_addr,
	input  wire logic [tccw_pkg::CELL_W-1:0] wr_data,
	input  wire logic                        rd_en,
	input  wire logic [AW-1:0]               rd_addr,
	output logic      [tccw_pkg::CELL_W-1:0] rd_data
);
	import tccw_pkg::*;

	logic [CELL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

// File: sv/tccw_sweep.sv
// Sequencer that clears the store after reset and scrolls it up one row.
`default_nettype none
module tccw_sweep #(
	parameter int CELL_COUNT = tccw_pkg::ROWS_DEF * tccw_pkg::COLUMNS_DEF,
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int AW = $clog2(CELL_COUNT)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output tccw_pkg::sweep_ctl_t      ctl,
	output logic         [AW-1:0]     rd_addr,
	output logic         [AW-1:0]     wr_addr
);
	import tccw_pkg::*;

	logic          run_q;
	logic          copy_mode_q;
	logic [AW-1:0] idx_q;
	logic          copy;
	logic          wv_s1;
	logic          copy_s1;
	logic [AW-1:0] idx_s1;

	assign copy = run_q && copy_mode_q && (32'(idx_q) < CELL_COUNT - COLUMNS);
	assign rd_addr = AW'(32'(idx_q) + COLUMNS);
	assign wr_addr = idx_s1;

	always_comb begin
		ctl.busy = run_q || wv_s1;
		ctl.rd_en = copy;
		ctl.wr_en = wv_s1;
		ctl.wr_zero = !copy_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b1;
			copy_mode_q <= 1'b0;
			idx_q <= '0;
			wv_s1 <= 1'b0;
		end else begin
			wv_s1 <= run_q;
			if (start) begin
				run_q <= 1'b1;
				copy_mode_q <= 1'b1;
				idx_q <= '0;
			end else if (run_q) begin
				if (32'(idx_q) == CELL_COUNT - 1) begin
					run_q <= 1'b0;
				end
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		copy_s1 <= copy;
	end
endmodule
`default_nettype wire

// File: sv/text_console_cursor_writer.sv
// A result passes through stage s1 and the output register after its item is accepted.
// Throughput: one item per cycle while results are taken and no sweep runs.
// A write that scrolls blocks input until its sweep ends: the sweep moves one cell a
// cycle through the single write port of the screen store.
// Reset: cursor at row 0 column 0, color 7; a clearing pass zeroes the store, and no item
// is accepted until it ends (color writes are taken as ever).
`default_nettype none
module text_console_cursor_writer #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS = tccw_pkg::ROWS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	tccw_in_if.sink                           in_ch,
	tccw_out_if.source                        out_ch,
	input  wire logic                         cfg_we,
	input  wire logic [tccw_pkg::COLOR_W-1:0] cfg_wdata
);
	import tccw_pkg::*;
	`include "assert_macros.svh"

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int AW = $clog2(CELL_COUNT);
	localparam int RW = $clog2(ROWS);
	localparam int RW1 = RW + 1;
	localparam int CW = $clog2(COLUMNS);

	logic [RW-1:0]      row_q;
	logic [CW-1:0]      col_q;
	logic [COLOR_W-1:0] color_q;

	logic [RW-1:0]  row_n;
	logic [CW-1:0]  col_n;
	logic [RW1-1:0] row_up;
	logic           row_inc;
	logic           scroll;
	logic           item_we;
	logic           rd_ok;
	logic           accept;
	logic           adv;
	action_t        act;

	logic          valid_s1;
	logic          rd_ok_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] col_s1;

	logic                 out_valid_q;
	logic [ROW_OUT_W-1:0] out_row_q;
	logic [COL_OUT_W-1:0] out_col_q;
	logic [ADDR_W-1:0]    out_pos_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic [COLOR_W-1:0]   out_color_q;

	sweep_ctl_t        sw_ctl;
	logic [AW-1:0]     sw_rd_addr;
	logic [AW-1:0]     sw_wr_addr;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [CELL_W-1:0] mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;
	logic [CELL_W-1:0] mem_rd;

	assign act = action_t'(in_ch.action);
	assign adv = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !sw_ctl.busy && (!valid_s1 || adv);
	assign accept = in_ch.valid && in_ch.ready;

	always_comb begin
		row_n = row_q;
		col_n = col_q;
		row_inc = 1'b0;
		row_up = {1'b0, row_q};
		scroll = 1'b0;
		item_we = 1'b0;
		rd_ok = 1'b0;
		unique case (act)
			ACT_WRITE: begin
				if (in_ch.char_byte == CHAR_LF || in_ch.char_byte == CHAR_CR) begin
					row_inc = 1'b1;
					col_n = '0;
				end else begin
					item_we = 1'b1;
					if (32'(col_q) == COLUMNS - 1) begin
						col_n = '0;
						row_inc = 1'b1;
					end else begin
						col_n = col_q + 1'b1;
					end
				end
				row_up = {1'b0, row_q} + RW1'(row_inc);
				if (32'(row_up) >= ROWS - 1) begin
					scroll = 1'b1;
					row_n = RW'(ROWS - 2);
					col_n = '0;
				end else begin
					row_n = row_up[RW-1:0];
				end
			end
			ACT_SET_ROW: begin
				if (32'(in_ch.position_value) > ROWS - 1) begin
					row_n = RW'(ROWS - 1);
				end else begin
					row_n = RW'(in_ch.position_value);
				end
			end
			ACT_SET_COL: begin
				if (32'(in_ch.position_value) > COLUMNS - 1) begin
					col_n = CW'(COLUMNS - 1);
				end else begin
					col_n = CW'(in_ch.position_value);
				end
			end
			ACT_READ: begin
				rd_ok = 32'(in_ch.cell_address) < CELL_COUNT;
			end
			default: begin
				rd_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (sw_ctl.wr_en) begin
			mem_we = 1'b1;
			mem_wa = sw_wr_addr;
			mem_wd = sw_ctl.wr_zero ? '0 : mem_rd;
		end else begin
			mem_we = accept && item_we;
			mem_wa = AW'(32'(row_q) * COLUMNS + 32'(col_q));
			mem_wd = {color_q, in_ch.char_byte};
		end
		if (sw_ctl.rd_en) begin
			mem_re = 1'b1;
			mem_ra = sw_rd_addr;
		end else begin
			mem_re = accept && rd_ok;
			mem_ra = AW'(32'(in_ch.cell_address));
		end
	end

	tccw_sweep #(
		.CELL_COUNT(CELL_COUNT),
		.COLUMNS(COLUMNS),
		.AW(AW)
	) u_sweep (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept && scroll),
		.ctl(sw_ctl),
		.rd_addr(sw_rd_addr),
		.wr_addr(sw_wr_addr)
	);

	tccw_screen_mem #(
		.DEPTH(CELL_COUNT),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.wr_en(mem_we),
		.wr_addr(mem_wa),
		.wr_data(mem_wd),
		.rd_en(mem_re),
		.rd_addr(mem_ra),
		.rd_data(mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			color_q <= TEXT_COLOR_RESET;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			if (accept) begin
				row_q <= row_n;
				col_q <= col_n;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1 <= row_n;
			col_s1 <= col_n;
			rd_ok_s1 <= rd_ok;
		end
		if (adv) begin
			out_row_q <= ROW_OUT_W'(32'(row_s1));
			out_col_q <= COL_OUT_W'(32'(col_s1));
			out_pos_q <= ADDR_W'(32'(row_s1) * COLUMNS + 32'(col_s1));
			out_char_q <= rd_ok_s1 ? mem_rd[CHAR_W-1:0] : '0;
			out_color_q <= rd_ok_s1 ? mem_rd[CELL_W-1:CHAR_W] : '0;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.caret_row = out_row_q;
	assign out_ch.caret_col = out_col_q;
	assign out_ch.cursor_position = out_pos_q;
	assign out_ch.cell_char = out_char_q;
	assign out_ch.cell_color = out_color_q;

	`TCCW_ASSERT_NEXT(a_scroll_starts_sweep, accept && scroll, sw_ctl.busy)
	`TCCW_ASSERT_NOW(a_no_write_collision, accept && item_we, !sw_ctl.wr_en)
	`TCCW_ASSERT_NOW(a_cursor_in_screen, 1'b1,
		(32'(row_q) <= ROWS - 1) && (32'(col_q) <= COLUMNS - 1))
endmodule
`default_nettype wire
